### src/gc_rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gc_rgb_pkg;

  localparam int unsigned NumCh   = 3;
  localparam int unsigned InW     = 24;
  localparam int unsigned OutW    = 17;
  localparam int unsigned GammaW  = 16;
  localparam int unsigned LogBits = 20;
  localparam int unsigned ExpBits = 20;
  localparam int unsigned ZW      = 31;
  localparam int unsigned RW      = 31;
  localparam int unsigned AW      = 25;
  localparam int unsigned EW      = AW + GammaW;
  localparam int unsigned NW      = EW - 32;
  localparam logic [GammaW-1:0] GammaReset = 16'd1862;
  localparam logic [OutW-1:0]   OutOne     = 17'd65536;
  localparam logic [OutW-1:0]   OutZero    = 17'd0;
  localparam logic [2:0]        AddrGamma  = 3'd0;

  typedef enum logic [1:0] {
    SP_NONE,
    SP_ZERO,
    SP_ONE
  } spec_e;

  function automatic logic [63:0] isqrt64(input logic [63:0] a);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    res   = '0;
    rem   = a;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] exp_coef(input int unsigned k);
    logic [63:0] c;
    logic [63:0] sel;
    c   = 64'd1 << 29;
    sel = '0;
    for (int unsigned i = 0; i < ExpBits; i++) begin
      c = isqrt64(c << 30);
      if (i == k) sel = c;
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

### src/gamma_correction_rgb.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-pixel gamma correction: each Q8.16 channel is raised to inverse_gamma (Q4.12,
// APB offset 0x0, reset 1862 = 1/2.2), clamped to 1.0 and returned as Q1.16. The power
// is 2^(y*log2 x): twenty squaring stages for the logarithm, one multiply stage, twenty
// conditional-multiply stages for the exponential and one rounding stage. One pixel
// enters per clock unless a valid output stalls; that freezes all 43 pipeline stages.
// Write inverse_gamma only while the pipeline is empty.
module gamma_correction_rgb
  import gc_rgb_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [InW-1:0]  red_in_i,
  input  wire logic [InW-1:0]  green_in_i,
  input  wire logic [InW-1:0]  blue_in_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [OutW-1:0]      red_out_o,
  output logic [OutW-1:0]      green_out_o,
  output logic [OutW-1:0]      blue_out_o
);

  localparam int unsigned SMul = LogBits + 1;
  localparam int unsigned SOut = SMul + ExpBits + 1;
  localparam int unsigned NS   = SOut + 1;

  logic [GammaW-1:0] gamma_q;
  logic              en;

  logic              vld_q  [NS];
  spec_e             sp_q   [SOut][NumCh];
  logic [ZW-1:0]     z_q    [SMul][NumCh];
  logic [LogBits-1:0] fr_q  [SMul][NumCh];
  logic [4:0]        ep_q   [SMul][NumCh];
  logic [NW-1:0]     n_q    [SMul:SOut-1][NumCh];
  logic [ExpBits-1:0] f_q   [SMul:SOut-1][NumCh];
  logic [RW-1:0]     r_q    [SMul:SOut-1][NumCh];
  logic [OutW-1:0]   out_q  [NumCh];
  logic [InW-1:0]    pix    [NumCh];

  assign pready = 1'b1;
  assign prdata = {{(32-GammaW){1'b0}}, gamma_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GammaReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == AddrGamma[2]) begin
      gamma_q <= pwdata[GammaW-1:0];
    end
  end

  assign en          = !(vld_q[NS-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NS-1];
  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];
  assign pix[0]      = red_in_i;
  assign pix[1]      = green_in_i;
  assign pix[2]      = blue_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) vld_q[s] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    logic [3:0]  lead;
    logic [15:0] norm;
    spec_e       sp_d;

    always_comb begin
      lead = '0;
      for (int b = 0; b < 16; b++) begin
        if (pix[c][b]) lead = 4'(b);
      end
      norm = pix[c][15:0] << (4'd15 - lead);
      if (gamma_q == '0) begin
        sp_d = SP_ONE;
      end else if (pix[c] == '0) begin
        sp_d = SP_ZERO;
      end else if (pix[c][InW-1:16] != '0) begin
        sp_d = SP_ONE;
      end else begin
        sp_d = SP_NONE;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sp_q[0][c] <= sp_d;
        z_q[0][c]  <= {norm, 15'd0};
        fr_q[0][c] <= '0;
        ep_q[0][c] <= 5'd16 - {1'b0, lead};
      end
    end

    for (genvar s = 1; s < SMul; s++) begin : g_log
      logic [2*ZW-1:0] sq;
      logic [31:0]     t;
      assign sq = z_q[s-1][c] * z_q[s-1][c];
      assign t  = sq[61:30];
      always_ff @(posedge clk_i) begin
        if (en) begin
          sp_q[s][c] <= sp_q[s-1][c];
          ep_q[s][c] <= ep_q[s-1][c];
          z_q[s][c]  <= t[31] ? t[31:1] : t[30:0];
          fr_q[s][c] <= {fr_q[s-1][c][LogBits-2:0], t[31]};
        end
      end
    end

    logic [AW-1:0] a_v;
    logic [EW-1:0] e_v;
    assign a_v = {ep_q[SMul-1][c], {LogBits{1'b0}}} - AW'(fr_q[SMul-1][c]);
    assign e_v = a_v * gamma_q;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sp_q[SMul][c] <= sp_q[SMul-1][c];
        n_q[SMul][c]  <= e_v[EW-1:32];
        f_q[SMul][c]  <= e_v[31:12];
        r_q[SMul][c]  <= RW'(1) << 30;
      end
    end

    for (genvar k = 0; k < ExpBits; k++) begin : g_exp
      localparam logic [63:0] Coef = exp_coef(k);
      logic [2*RW-1:0] pr;
      assign pr = r_q[SMul+k][c] * Coef[RW-1:0];
      always_ff @(posedge clk_i) begin
        if (en) begin
          sp_q[SMul+k+1][c] <= sp_q[SMul+k][c];
          n_q[SMul+k+1][c]  <= n_q[SMul+k][c];
          f_q[SMul+k+1][c]  <= f_q[SMul+k][c];
          r_q[SMul+k+1][c]  <= f_q[SMul+k][c][ExpBits-1-k] ? pr[60:30] : r_q[SMul+k][c];
        end
      end
    end

    logic [54:0]     sum;
    logic [54:0]     shr;
    logic [OutW-1:0] res;
    logic [5:0]      nn;
    always_comb begin
      nn  = n_q[SOut-1][c][5:0];
      sum = 55'(r_q[SOut-1][c]) + (55'd1 << (6'd13 + nn));
      shr = sum >> (6'd14 + nn);
      if (n_q[SOut-1][c] > NW'(40)) begin
        res = OutZero;
      end else if (shr > 55'(OutOne)) begin
        res = OutOne;
      end else begin
        res = shr[OutW-1:0];
      end
      case (sp_q[SOut-1][c])
        SP_ZERO: res = OutZero;
        SP_ONE:  res = OutOne;
        default: ;
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        out_q[c] <= res;
      end
    end
  end

endmodule

`default_nettype wire

### src/gc_rgb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gc_rgb_checker
  import gc_rgb_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            pready,
  input wire logic            in_valid_i,
  input wire logic            in_stall_o,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire logic [OutW-1:0] red_out_o,
  input wire logic [OutW-1:0] green_out_o,
  input wire logic [OutW-1:0] blue_out_o
);

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_out_o <= OutOne && green_out_o <= OutOne && blue_out_o <= OutOne))
    else $error("result above 1.0");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(red_out_o)
      && $stable(green_out_o) && $stable(blue_out_o)))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind gamma_correction_rgb gc_rgb_checker u_gc_rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .red_out_o   (red_out_o),
  .green_out_o (green_out_o),
  .blue_out_o  (blue_out_o)
);

`default_nettype wire
